@@ rtl/rational_add_divide_reduce_unit_assert.svh @@
// Assertion macros used by the bound checker file.
`ifndef RATIONAL_ADD_DIVIDE_REDUCE_UNIT_ASSERT_SVH
`define RATIONAL_ADD_DIVIDE_REDUCE_UNIT_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define RADR_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define RADR_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ rtl/radr_pkg.sv @@
package radr_pkg;

  localparam int FIELD_W = 32;
  localparam int MAG_W   = 64;

  localparam logic [1:0] REQ_REDUCE = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_DIVIDE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_GCD_ZERO = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic signed [63:0] res_den;
    logic [1:0]         status;
  } res_t;

  // Datapath operations selected by the controller.
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_MUL1  = 3'd2,
    OP_MUL2  = 3'd3,
    OP_RAW   = 3'd4,
    OP_DIVST = 3'd5,
    OP_DIVEN = 3'd6
  } dp_op_t;

  typedef enum logic [1:0] {
    DV_GCD  = 2'd0,
    DV_QNUM = 2'd1,
    DV_QDEN = 2'd2
  } dv_sel_t;

  typedef struct packed {
    dp_op_t  op;
    dv_sel_t dsel;
    logic    done;
  } dp_cmd_t;

  typedef struct packed {
    logic y_zero;
    logic g_zero;
    logic div_busy;
  } dp_stat_t;

endpackage

@@ rtl/radr_divider.sv @@
// Restoring unsigned divider, one quotient bit a cycle.
module radr_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [radr_pkg::MAG_W-1:0] dividend,
  input  logic [radr_pkg::MAG_W-1:0] divisor,
  output logic                     busy,
  output logic [radr_pkg::MAG_W-1:0] quo,
  output logic [radr_pkg::MAG_W-1:0] rem
);
  localparam int W = radr_pkg::MAG_W;
  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  dsr;
  logic [W:0]    trial;

  assign trial = {rem, quo[W-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cnt  <= CW'(W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end
endmodule

@@ rtl/radr_datapath.sv @@
module radr_datapath #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  radr_pkg::req_t      req,
  input  radr_pkg::dp_cmd_t   cmd,
  output radr_pkg::dp_stat_t  stat,
  output radr_pkg::res_t      res
);
  localparam int W = radr_pkg::MAG_W;
  localparam int OW = OPERAND_WIDTH;

  logic [1:0]    sel;
  logic          an_s, ad_s, bn_s, bd_s;
  logic [OW-1:0] an_m, ad_m, bn_m, bd_m;
  logic [W-1:0]  p1, p2, p3;
  logic          p1_s, p2_s, p3_s;
  logic [W-1:0]  num_m, den_m;
  logic          num_s, den_s;
  logic [W-1:0]  x, y;
  logic          steps;
  logic [W-1:0]  gcd_m;
  logic          gcd_s;
  logic [W-1:0]  qn, qd;
  logic          ovf;

  logic          dgo, dbusy;
  logic [W-1:0]  dvd, dvs, dquo, drem;

  function automatic logic [OW:0] load_op(input logic [radr_pkg::FIELD_W-1:0] raw);
    logic [OW-1:0] v;
    v = raw[OW-1:0];
    if (v[OW-1]) return {1'b1, (~v) + 1'b1};
    return {1'b0, v};
  endfunction

  function automatic logic [W-1:0] widen(input logic [OW-1:0] v);
    return W'(v);
  endfunction

  // Pick the two products formed in the current multiply step.
  logic [OW-1:0] ma, mb, mc, md;
  logic          mx_s, my_s;
  always_comb begin
    ma = an_m; mb = bd_m; mc = ad_m; md = bd_m;
    mx_s = an_s ^ bd_s; my_s = ad_s ^ bd_s;
    if (cmd.op == radr_pkg::OP_MUL2) begin
      ma = bn_m; mb = ad_m; mc = ad_m; md = bn_m;
      mx_s = bn_s ^ ad_s; my_s = ad_s ^ bn_s;
    end
  end

  logic [W-1:0] sum_m;
  logic         sum_s;
  always_comb begin
    if (p1_s == p3_s) begin
      sum_m = p1 + p3; sum_s = p1_s;
    end else if (p1 >= p3) begin
      sum_m = p1 - p3; sum_s = p1_s;
    end else begin
      sum_m = p3 - p1; sum_s = p3_s;
    end
    if (sum_m == '0) sum_s = 1'b0;
  end

  always_comb begin
    dgo = (cmd.op == radr_pkg::OP_DIVST);
    unique case (cmd.dsel)
      radr_pkg::DV_QNUM: begin dvd = num_m; dvs = gcd_m; end
      radr_pkg::DV_QDEN: begin dvd = den_m; dvs = gcd_m; end
      default:           begin dvd = x;     dvs = y;     end
    endcase
  end

  radr_divider u_div (
    .clk(clk), .rst(rst), .go(dgo), .dividend(dvd), .divisor(dvs),
    .busy(dbusy), .quo(dquo), .rem(drem)
  );

  logic [OW:0] t0, t1, t2, t3;
  assign t0 = load_op(req.a_num);
  assign t1 = load_op(req.a_den);
  assign t2 = load_op(req.b_num);
  assign t3 = load_op(req.b_den);

  // Two's complement of a truncated quotient.
  function automatic logic [W-1:0] to_tc(input logic [W-1:0] q, input logic neg);
    if (neg && q != '0) return (~q) + 1'b1;
    return q;
  endfunction

  logic [W-1:0] tn, td;
  assign tn = to_tc(qn, num_s ^ gcd_s);
  assign td = to_tc(qd, den_s ^ gcd_s);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      radr_pkg::OP_LOAD: begin
        sel <= req.req_type;
        {an_s, an_m} <= t0; {ad_s, ad_m} <= t1;
        {bn_s, bn_m} <= t2; {bd_s, bd_m} <= t3;
        steps <= 1'b0;
      end
      radr_pkg::OP_MUL1: begin
        p1 <= W'(widen(ma) * widen(mb)); p1_s <= mx_s;
        p2 <= W'(widen(mc) * widen(md)); p2_s <= my_s;
      end
      radr_pkg::OP_MUL2: begin
        p3 <= W'(widen(ma) * widen(mb)); p3_s <= mx_s;
        if (sel == radr_pkg::REQ_DIVIDE) begin
          p2 <= W'(widen(mc) * widen(md)); p2_s <= my_s;
        end
      end
      radr_pkg::OP_RAW: begin
        if (sel == radr_pkg::REQ_ADD) begin
          num_m <= sum_m; num_s <= sum_s;
          den_m <= p2; den_s <= (p2 != '0) && p2_s;
          x <= sum_m; y <= p2;
        end else if (sel == radr_pkg::REQ_DIVIDE) begin
          num_m <= p1; num_s <= (p1 != '0) && p1_s;
          den_m <= p2; den_s <= (p2 != '0) && p2_s;
          x <= p1; y <= p2;
        end else begin
          num_m <= widen(an_m); num_s <= an_s;
          den_m <= widen(ad_m); den_s <= ad_s;
          x <= widen(an_m); y <= widen(ad_m);
        end
      end
      radr_pkg::OP_DIVEN: begin
        unique case (cmd.dsel)
          radr_pkg::DV_QNUM: qn <= dquo;
          radr_pkg::DV_QDEN: qd <= dquo;
          default: begin
            x <= y; y <= drem; steps <= ~steps;
          end
        endcase
      end
      default: begin end
    endcase
  end

  always_comb begin
    gcd_m = x;
    gcd_s = (x != '0) && (steps ? den_s : num_s);
  end

  assign stat.y_zero   = (y == '0);
  assign stat.g_zero   = (x == '0);
  assign stat.div_busy = dbusy;

  // A positive quotient with the top bit set does not fit.
  assign ovf = (!(num_s ^ gcd_s) && qn[W-1]) || (!(den_s ^ gcd_s) && qd[W-1]);

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      if (x == '0) begin
        res.res_num <= '0; res.res_den <= '0; res.status <= radr_pkg::ST_GCD_ZERO;
      end else if (ovf) begin
        res.res_num <= '0; res.res_den <= '0; res.status <= radr_pkg::ST_OVERFLOW;
      end else begin
        res.res_num <= tn; res.res_den <= td;
        res.status  <= radr_pkg::ST_OK;
      end
    end
  end
endmodule

@@ rtl/radr_ctrl.sv @@
module radr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  radr_pkg::dp_stat_t stat,
  output radr_pkg::dp_cmd_t  cmd
);
  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_MUL1   = 11'b00000000010,
    S_MUL2   = 11'b00000000100,
    S_RAW    = 11'b00000001000,
    S_GTEST  = 11'b00000010000,
    S_GWAIT  = 11'b00000100000,
    S_QNUM   = 11'b00001000000,
    S_QNWAIT = 11'b00010000000,
    S_QDEN   = 11'b00100000000,
    S_QDWAIT = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic   done_next;

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd.op   = radr_pkg::OP_NONE;
    cmd.dsel = radr_pkg::DV_GCD;
    cmd.done = 1'b0;
    unique case (state)
      S_IDLE: if (start) begin
        cmd.op = radr_pkg::OP_LOAD; state_next = S_MUL1;
      end
      S_MUL1: begin cmd.op = radr_pkg::OP_MUL1; state_next = S_MUL2; end
      S_MUL2: begin cmd.op = radr_pkg::OP_MUL2; state_next = S_RAW; end
      S_RAW:  begin cmd.op = radr_pkg::OP_RAW;  state_next = S_GTEST; end
      S_GTEST: begin
        if (!stat.y_zero) begin
          cmd.op = radr_pkg::OP_DIVST; state_next = S_GWAIT;
        end else if (stat.g_zero) begin
          state_next = S_OUT;
        end else begin
          state_next = S_QNUM;
        end
      end
      S_GWAIT: if (!stat.div_busy) begin
        cmd.op = radr_pkg::OP_DIVEN; state_next = S_GTEST;
      end
      S_QNUM: begin
        cmd.dsel = radr_pkg::DV_QNUM;
        cmd.op = radr_pkg::OP_DIVST; state_next = S_QNWAIT;
      end
      S_QNWAIT: begin
        cmd.dsel = radr_pkg::DV_QNUM;
        if (!stat.div_busy) begin
          cmd.op = radr_pkg::OP_DIVEN; state_next = S_QDEN;
        end
      end
      S_QDEN: begin
        cmd.dsel = radr_pkg::DV_QDEN;
        cmd.op = radr_pkg::OP_DIVST; state_next = S_QDWAIT;
      end
      S_QDWAIT: begin
        cmd.dsel = radr_pkg::DV_QDEN;
        if (!stat.div_busy) begin
          cmd.op = radr_pkg::OP_DIVEN; state_next = S_OUT;
        end
      end
      S_OUT: begin cmd.done = 1'b1; done_next = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);
endmodule

@@ rtl/rational_add_divide_reduce_unit.sv @@
// Sequence: after the accepting edge the controller loads, cross multiplies, runs Euclid
// remainder steps, then divides out the numerator and denominator; when both raw parts
// are 0 it goes straight to output. One shared 64-bit bit-serial divider does each division.
// Handshake: one transaction at a time; start is taken while busy is low, at the
// earliest in the done cycle; no receiver stall.
// Reset: synchronous, active high; returns to idle and drops any transaction.
module rational_add_divide_reduce_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  radr_pkg::req_t req,
  output logic           busy,
  output logic           done,
  output radr_pkg::res_t res
);
  radr_pkg::dp_cmd_t  cmd;
  radr_pkg::dp_stat_t stat;

  // Controller sequences load, cross multiply, Euclid loop and the two quotients.
  radr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .stat(stat), .cmd(cmd)
  );

  // Datapath holds operands, products, the Euclid pair and the shared divider.
  radr_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .req(req), .cmd(cmd), .stat(stat), .res(res)
  );
endmodule

@@ rtl/radr_checker.sv @@
`include "rational_add_divide_reduce_unit_assert.svh"
module radr_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input radr_pkg::res_t res
);
  `RADR_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "start did not raise busy")
  `RADR_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "done while busy")
  `RADR_ASSERT_IMPL(a_status_ok, clk, rst, done, res.status == radr_pkg::ST_OK || res.status == radr_pkg::ST_OVERFLOW || res.status == radr_pkg::ST_GCD_ZERO, "bad status")
  `RADR_ASSERT_IMPL(a_zero_res, clk, rst, done && res.status != radr_pkg::ST_OK, res.res_num == 64'd0 && res.res_den == 64'd0, "nonzero parts on error")
endmodule

bind rational_add_divide_reduce_unit radr_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .res(res)
);

@@ tb/rational_add_divide_reduce_unit_checker.sv @@
`timescale 1ns / 100ps

module rational_add_divide_reduce_unit_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  radr_pkg::req_t req,
  input  logic           done,
  input  radr_pkg::res_t res,
  output int             errors,
  output int             pending
);
  typedef struct {
    bit        neg;
    bit [63:0] mag;
  } smag_s;

  radr_pkg::res_t fraction_q[$];

  function automatic smag_s to_smag(logic signed [31:0] v);
    smag_s r;
    r.neg = v[31];
    r.mag = v[31] ? 64'(-64'(signed'(v))) : 64'(v);
    return r;
  endfunction

  function automatic smag_s mul_sm(smag_s x, smag_s y);
    smag_s r;
    r.mag = x.mag * y.mag;
    r.neg = (r.mag != 0) && (x.neg != y.neg);
    return r;
  endfunction

  function automatic smag_s add_sm(smag_s x, smag_s y);
    smag_s r;
    if (x.neg == y.neg) begin
      r.mag = x.mag + y.mag;
      r.neg = x.neg;
    end else if (x.mag >= y.mag) begin
      r.mag = x.mag - y.mag;
      r.neg = x.neg;
    end else begin
      r.mag = y.mag - x.mag;
      r.neg = y.neg;
    end
    if (r.mag == 0) r.neg = 0;
    return r;
  endfunction

  // Quotient as two's complement; returns 0 when it does not fit.
  function automatic bit quot_fits(smag_s n, smag_s g, output logic [63:0] q_out);
    bit [63:0] q;
    q = n.mag / g.mag;
    if ((q != 0) && (n.neg != g.neg)) begin
      q_out = 64'd0 - q;
      return 1;
    end
    q_out = q;
    return q <= 64'h7fff_ffff_ffff_ffff;
  endfunction

  function automatic radr_pkg::res_t reduce_fraction(radr_pkg::req_t r);
    smag_s an, ad, bn, bd, num, den, g;
    bit [63:0] x, y, t;
    bit odd;
    logic [63:0] qn, qd;
    radr_pkg::res_t o;
    an = to_smag(r.a_num);
    ad = to_smag(r.a_den);
    bn = to_smag(r.b_num);
    bd = to_smag(r.b_den);
    if (r.req_type == radr_pkg::REQ_ADD) begin
      num = add_sm(mul_sm(an, bd), mul_sm(bn, ad));
      den = mul_sm(ad, bd);
    end else if (r.req_type == radr_pkg::REQ_DIVIDE) begin
      num = mul_sm(an, bd);
      den = mul_sm(ad, bn);
    end else begin
      num = an;
      den = ad;
    end
    // Euclid on magnitudes; sign follows the last nonzero remainder.
    x = num.mag;
    y = den.mag;
    odd = 0;
    while (y != 0) begin
      t = y;
      y = x % y;
      x = t;
      odd = ~odd;
    end
    g.mag = x;
    g.neg = (x != 0) && (odd ? den.neg : num.neg);
    o.res_num = '0;
    o.res_den = '0;
    o.status = radr_pkg::ST_OK;
    if (g.mag == 0) begin
      o.status = radr_pkg::ST_GCD_ZERO;
    end else if (!quot_fits(num, g, qn) || !quot_fits(den, g, qd)) begin
      o.status = radr_pkg::ST_OVERFLOW;
    end else begin
      o.res_num = qn;
      o.res_den = qd;
    end
    return o;
  endfunction

  always @(posedge clk) begin
    radr_pkg::res_t want;
    if (rst) begin
      errors  <= 0;
      pending <= 0;
    end else begin
      if (start && !busy) fraction_q.push_back(reduce_fraction(req));
      if (done) begin
        if (fraction_q.size() == 0) begin
          $display("%0t: unexpected result num=%0d den=%0d status=%0d",
                   $time, res.res_num, res.res_den, res.status);
          errors <= errors + 1;
        end else begin
          want = fraction_q.pop_front();
          if (want.res_num !== res.res_num)
            $display("%0t: res_num expected %0d actual %0d", $time,
                     want.res_num, res.res_num);
          if (want.res_den !== res.res_den)
            $display("%0t: res_den expected %0d actual %0d", $time,
                     want.res_den, res.res_den);
          if (want.status !== res.status)
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, res.status);
          if (want !== res) errors <= errors + 1;
        end
      end
      pending <= fraction_q.size();
    end
  end
endmodule

@@ tb/rational_add_divide_reduce_unit_tb.sv @@
`timescale 1ns / 100ps

module rational_add_divide_reduce_unit_tb;
  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 12000000;

  logic           clk;
  logic           rst;
  logic           start;
  radr_pkg::req_t req;
  logic           busy;
  logic           done;
  radr_pkg::res_t res;
  int             errors;
  int             pending;
  int             cycles = 0;
  int             type_count[4];

  rational_add_divide_reduce_unit u_top (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .res(res)
  );

  rational_add_divide_reduce_unit_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .res(res), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rational_add_divide_reduce_unit regression: fail");
      $finish;
    end
  end

  // Present one transaction at the falling edge and hold it until accepted.
  // Start stays high afterward so back-to-back transactions need no gap.
  task automatic send_fraction(radr_pkg::req_t r);
    @(negedge clk);
    start <= 1'b1;
    req <= r;
    while (busy) @(negedge clk);
    @(posedge clk);
    type_count[r.req_type]++;
  endtask

  // Drop start for a gap of the given length.
  task automatic idle_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      req <= {$urandom, $urandom, $urandom, $urandom, 2'($urandom)};
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 2)) - 32'd1;
      3, 4: return $urandom;
      5: return 32'($urandom_range(0, 1) ? 1 << $urandom_range(0, 31) :
                    -(1 << $urandom_range(0, 31)));
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic radr_pkg::req_t make_req(logic [1:0] t, logic [31:0] an,
                                              logic [31:0] ad, logic [31:0] bn,
                                              logic [31:0] bd);
    radr_pkg::req_t r;
    r.req_type = t;
    r.a_num = an;
    r.a_den = ad;
    r.b_num = bn;
    r.b_den = bd;
    return r;
  endfunction

  initial begin
    radr_pkg::req_t r;
    int   burst;
    int   waited;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every operation, zeros, extremes, ignored second fraction.
    send_fraction(make_req(radr_pkg::REQ_REDUCE, 32'd6, 32'd4, 32'h7fff_ffff, 32'h8000_0000));
    send_fraction(make_req(radr_pkg::REQ_REDUCE, -32'd6, 32'd4, 32'd0, 32'd0));
    send_fraction(make_req(radr_pkg::REQ_REDUCE, 32'd6, -32'd4, 32'd1, 32'd1));
    send_fraction(make_req(radr_pkg::REQ_REDUCE, 32'd0, 32'd0, 32'd5, 32'd7));
    send_fraction(make_req(radr_pkg::REQ_REDUCE, 32'd0, 32'd5, 32'd0, 32'd0));
    send_fraction(make_req(radr_pkg::REQ_REDUCE, 32'd5, 32'd0, 32'd0, 32'd0));
    send_fraction(make_req(radr_pkg::REQ_REDUCE, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd0));
    send_fraction(make_req(radr_pkg::REQ_REDUCE, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0));
    send_fraction(make_req(radr_pkg::REQ_REDUCE, 32'h7fff_ffff, 32'h7fff_fffe, 32'd0, 32'd0));
    send_fraction(make_req(2'd3, 32'd10, -32'd15, 32'd3, 32'd4));
    send_fraction(make_req(radr_pkg::REQ_ADD, 32'd1, 32'd2, 32'd1, 32'd3));
    send_fraction(make_req(radr_pkg::REQ_ADD, 32'd1, 32'd2, -32'd1, 32'd2));
    send_fraction(make_req(radr_pkg::REQ_ADD, 32'd0, 32'd0, 32'd0, 32'd0));
    send_fraction(make_req(radr_pkg::REQ_ADD, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000));
    send_fraction(make_req(radr_pkg::REQ_ADD, 32'h7fff_ffff, 32'h8000_0000,
                           32'h7fff_ffff, 32'h7fff_ffff));
    send_fraction(make_req(radr_pkg::REQ_ADD, 32'h8000_0000, 32'h7fff_ffff,
                           32'h8000_0000, 32'h7fff_fffe));
    send_fraction(make_req(radr_pkg::REQ_DIVIDE, 32'd2, 32'd3, 32'd4, 32'd5));
    send_fraction(make_req(radr_pkg::REQ_DIVIDE, 32'd2, 32'd3, 32'd0, 32'd5));
    send_fraction(make_req(radr_pkg::REQ_DIVIDE, 32'd0, 32'd3, 32'd0, 32'd5));
    send_fraction(make_req(radr_pkg::REQ_DIVIDE, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000));
    send_fraction(make_req(radr_pkg::REQ_DIVIDE, 32'h7fff_ffff, 32'h8000_0000,
                           32'h8000_0000, 32'h7fff_ffff));
    send_fraction(make_req(radr_pkg::REQ_DIVIDE, -32'd7, 32'd3, -32'd9, -32'd14));
    idle_gap(3);

    // Random: bursts of transactions separated by random gaps.
    for (int i = 0; i < RANDOM_ITEMS; ) begin
      burst = $urandom_range(1, 8);
      for (int j = 0; j < burst && i < RANDOM_ITEMS; j++, i++) begin
        r = make_req(2'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2)),
                     pick_value(), pick_value(), pick_value(), pick_value());
        send_fraction(r);
      end
      idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40));
    end
    @(negedge clk);
    start <= 1'b0;

    // Drain outstanding results, then linger a little.
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);

    $display("covered %0d reduce, %0d add, %0d divide, %0d selector-three transactions",
             type_count[0], type_count[1], type_count[2], type_count[3]);
    $display("with bursts, gaps, zero parts and operand extremes; %0d mismatches",
             errors);
    if (errors == 0 && pending == 0) begin
      $display("rational_add_divide_reduce_unit regression: pass");
    end else begin
      $display("rational_add_divide_reduce_unit regression: fail");
    end
    $finish;
  end
endmodule
